### sv/rrs_pkg.sv
// rrs_pkg: shared types and constants for the running regression slope unit
// depends on nothing; used by rrs_mul, rrs_div and the top level
package rrs_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned PCNT_W = 16;

  // request to the shared serial divider
  typedef struct packed {
    logic              start;
    logic              frac;   // 1: run the extra fraction steps of a slope division
    logic [PROD_W-1:0] num;
    logic [PROD_W-1:0] den;
  } div_req_t;

  // answer from the shared serial divider
  typedef struct packed {
    logic              done;
    logic              big;    // quotient exceeded 32 bits
    logic [PROD_W-1:0] quo;
  } div_rsp_t;

endpackage

### sv/rrs_mul.sv
// rrs_mul: bit-serial signed 32x32 multiplier, one multiplier bit per cycle
// depends on rrs_pkg
module rrs_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [rrs_pkg::VAL_W-1:0] a_i,
  input  logic signed [rrs_pkg::VAL_W-1:0] b_i,
  output logic                             done_o,
  output logic        [rrs_pkg::PROD_W-1:0] p_o
);

  logic                          busy_q, fin_q, neg_q;
  logic [4:0]                    cnt_q;
  logic [rrs_pkg::VAL_W-1:0]     amag_q;
  logic [rrs_pkg::PROD_W-1:0]    prod_q;
  logic [rrs_pkg::VAL_W:0]       sum;
  logic [rrs_pkg::VAL_W-1:0]     amag, bmag;

  assign amag = a_i[rrs_pkg::VAL_W-1] ? (~a_i + 1'b1) : a_i;
  assign bmag = b_i[rrs_pkg::VAL_W-1] ? (~b_i + 1'b1) : b_i;
  assign sum  = {1'b0, prod_q[rrs_pkg::PROD_W-1:rrs_pkg::VAL_W]}
              + (prod_q[0] ? {1'b0, amag_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      amag_q <= amag;
      prod_q <= {{rrs_pkg::VAL_W{1'b0}}, bmag};
      neg_q  <= a_i[rrs_pkg::VAL_W-1] ^ b_i[rrs_pkg::VAL_W-1];
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[rrs_pkg::VAL_W-1:1]};
    end
  end

  assign done_o = fin_q;
  assign p_o    = neg_q ? (~prod_q + 1'b1) : prod_q;

endmodule

### sv/rrs_div.sv
// rrs_div: shared restoring divider, one quotient bit per cycle
// depends on rrs_pkg
module rrs_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrs_pkg::div_req_t req_i,
  output rrs_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = rrs_pkg::PROD_W + FRAC_BITS;
  localparam int unsigned SW = $clog2(DW + 1);

  logic                       busy_q, fin_q, ovf_q;
  logic [SW-1:0]              cnt_q, last_q;
  logic [DW-1:0]              sh_q;
  logic [rrs_pkg::PROD_W-1:0] r_q, q_q, den_q;
  logic [rrs_pkg::PROD_W:0]   r2, rsub;
  logic                       ge;

  assign r2   = {r_q, sh_q[DW-1]};
  assign rsub = r2 - {1'b0, den_q};
  assign ge   = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == last_q - 1'b1) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q   <= {req_i.num, {FRAC_BITS{1'b0}}};
      den_q  <= req_i.den;
      r_q    <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
      last_q <= req_i.frac ? SW'(DW) : SW'(rrs_pkg::PROD_W);
    end else if (busy_q) begin
      sh_q  <= {sh_q[DW-2:0], 1'b0};
      r_q   <= ge ? rsub[rrs_pkg::PROD_W-1:0] : r2[rrs_pkg::PROD_W-1:0];
      q_q   <= {q_q[rrs_pkg::PROD_W-2:0], ge};
      ovf_q <= ovf_q | q_q[rrs_pkg::PROD_W-1];
    end
  end

  assign rsp_o.done = fin_q;
  assign rsp_o.quo  = q_q;
  assign rsp_o.big  = ovf_q | (|q_q[rrs_pkg::PROD_W-1:rrs_pkg::VAL_W]);

endmodule

### sv/running_regression_slope_unit.sv
// running least-squares slope over a stream of (x, y) words, Q format with FRAC_BITS
// point word: S_MUL_XY, S_MUL_XX, the mean updates in S_MEAN, S_MUL_MXY, S_MUL_MXX, then
// the slope division in S_SLOPE and S_OUT; the next word is taken only back in S_IDLE; zero
// variance skips the slope division, and a clear word zeroes count and means and starts at
// S_MUL_MXY; a result still waiting in the output register holds the next one in S_OUT
// rst_ni clears the count, all means and the output register; no clearing pass
module running_regression_slope_unit #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  mode_i,
  input  logic signed [rrs_pkg::VAL_W-1:0]      x_value_i,
  input  logic signed [rrs_pkg::VAL_W-1:0]      y_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [rrs_pkg::VAL_W-1:0]      slope_o,
  output logic                                  degenerate_o,
  output logic        [rrs_pkg::PCNT_W-1:0]     point_count_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_XY, S_MUL_XX, S_MEAN, S_MUL_MXY, S_MUL_MXX, S_SLOPE, S_OUT
  } state_e;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_e state_q;
  logic   run_q;      // unit launched for the current state
  logic [1:0] sel_q;  // which mean is being updated: x, y, xy, xsq

  // running state
  logic [COUNT_BITS-1:0]             count_q;
  logic signed [rrs_pkg::VAL_W-1:0]  mean_x_q, mean_y_q;
  logic signed [rrs_pkg::PROD_W-1:0] mean_xy_q, mean_xsq_q;

  // latched word and products
  logic signed [rrs_pkg::VAL_W-1:0]  x_q, y_q;
  logic signed [rrs_pkg::PROD_W-1:0] pa_q, pb_q;
  logic                              dneg_q, sneg_q;

  // finished result, waiting for the output register
  logic                              degen_q;
  logic signed [rrs_pkg::VAL_W-1:0]  slope_q;
  logic [rrs_pkg::PCNT_W-1:0]        pcnt_q;

  // output register
  logic                              out_valid_q, odegen_q, out_load;
  logic signed [rrs_pkg::VAL_W-1:0]  oslope_q;
  logic [rrs_pkg::PCNT_W-1:0]        opcnt_q;

  // multiplier
  logic                              mul_start, mul_done;
  logic signed [rrs_pkg::VAL_W-1:0]  mul_a, mul_b;
  logic [rrs_pkg::PROD_W-1:0]        mul_p;

  rrs_pkg::div_req_t div_req;
  rrs_pkg::div_rsp_t div_rsp;

  rrs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  rrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // multiplier operands: sample products first, then products of the means
  always_comb begin
    mul_a = x_q;
    mul_b = y_q;
    case (state_q)
      S_MUL_XY:  begin mul_a = x_q;      mul_b = y_q;      end
      S_MUL_XX:  begin mul_a = x_q;      mul_b = x_q;      end
      S_MUL_MXY: begin mul_a = mean_x_q; mul_b = mean_y_q; end
      S_MUL_MXX: begin mul_a = mean_x_q; mul_b = mean_x_q; end
      default:   begin mul_a = x_q;      mul_b = y_q;      end
    endcase
  end

  assign mul_start = !run_q && (state_q == S_MUL_XY || state_q == S_MUL_XX ||
                                state_q == S_MUL_MXY || state_q == S_MUL_MXX);

  // mean update: old mean m, new value v, signed difference v - m
  logic signed [rrs_pkg::PROD_W-1:0] m_sel, v_sel;
  logic        [rrs_pkg::PROD_W:0]   mdiff;
  logic        [rrs_pkg::PROD_W-1:0] mmag;
  logic                              mneg;

  always_comb begin
    case (sel_q)
      2'd0:    begin m_sel = 64'(mean_x_q); v_sel = 64'(x_q); end
      2'd1:    begin m_sel = 64'(mean_y_q); v_sel = 64'(y_q); end
      2'd2:    begin m_sel = mean_xy_q;     v_sel = pa_q;     end
      default: begin m_sel = mean_xsq_q;    v_sel = pb_q;     end
    endcase
  end

  assign mdiff = {v_sel[rrs_pkg::PROD_W-1], v_sel} - {m_sel[rrs_pkg::PROD_W-1], m_sel};
  assign mneg  = mdiff[rrs_pkg::PROD_W];
  assign mmag  = mneg ? (~mdiff[rrs_pkg::PROD_W-1:0] + 1'b1) : mdiff[rrs_pkg::PROD_W-1:0];

  // slope operands: covariance over variance, as magnitudes and signs
  logic [rrs_pkg::PROD_W:0]   ndiff, ddiff;
  logic [rrs_pkg::PROD_W-1:0] nmag, dmag;

  assign ndiff = {mean_xy_q[rrs_pkg::PROD_W-1], mean_xy_q} - {pa_q[rrs_pkg::PROD_W-1], pa_q};
  assign ddiff = {mean_xsq_q[rrs_pkg::PROD_W-1], mean_xsq_q} - {pb_q[rrs_pkg::PROD_W-1], pb_q};
  assign nmag  = ndiff[rrs_pkg::PROD_W] ? (~ndiff[rrs_pkg::PROD_W-1:0] + 1'b1)
                                        : ndiff[rrs_pkg::PROD_W-1:0];
  assign dmag  = ddiff[rrs_pkg::PROD_W] ? (~ddiff[rrs_pkg::PROD_W-1:0] + 1'b1)
                                        : ddiff[rrs_pkg::PROD_W-1:0];

  always_comb begin
    div_req.start = 1'b0;
    div_req.frac  = 1'b0;
    div_req.num   = mmag;
    div_req.den   = {{(rrs_pkg::PROD_W-COUNT_BITS){1'b0}}, count_q};
    if (state_q == S_MEAN && !run_q) begin
      div_req.start = 1'b1;
    end else if (state_q == S_SLOPE) begin
      div_req.frac  = 1'b1;
      div_req.num   = nmag;
      div_req.den   = dmag;
      div_req.start = !run_q && (dmag != '0);
    end
  end

  // saturated quotient, sign applied
  logic [rrs_pkg::VAL_W-1:0] sat_slope;
  logic [rrs_pkg::VAL_W:0]   qlow;

  assign qlow = div_rsp.quo[rrs_pkg::VAL_W:0];

  always_comb begin
    if (sneg_q) begin
      if (div_rsp.big || qlow > {1'b0, 32'h8000_0000}) sat_slope = 32'h8000_0000;
      else sat_slope = ~qlow[rrs_pkg::VAL_W-1:0] + 1'b1;
    end else begin
      if (div_rsp.big || qlow > {1'b0, 32'h7FFF_FFFF}) sat_slope = 32'h7FFF_FFFF;
      else sat_slope = qlow[rrs_pkg::VAL_W-1:0];
    end
  end

  // point count shown saturated at 16 bits
  logic [32:0] cnt_ext;
  logic [rrs_pkg::PCNT_W-1:0] cnt_show;

  assign cnt_ext  = {{(33-COUNT_BITS){1'b0}}, count_q};
  assign cnt_show = (cnt_ext > 33'd65535) ? {rrs_pkg::PCNT_W{1'b1}}
                                          : cnt_ext[rrs_pkg::PCNT_W-1:0];

  logic [rrs_pkg::PROD_W-1:0] mnew;
  logic                       mneg_q;
  assign mnew = mneg_q ? (m_sel - div_rsp.quo) : (m_sel + div_rsp.quo);

  // finished result moves to the output register once that is free
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= 1'b0;
      sel_q       <= '0;
      count_q     <= '0;
      mean_x_q    <= '0;
      mean_y_q    <= '0;
      mean_xy_q   <= '0;
      mean_xsq_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            run_q <= 1'b0;
            sel_q <= '0;
            if (mode_i) begin
              // clear word: zero the count and all means, then form the (degenerate) result
              count_q    <= '0;
              mean_x_q   <= '0;
              mean_y_q   <= '0;
              mean_xy_q  <= '0;
              mean_xsq_q <= '0;
              state_q    <= S_MUL_MXY;
            end else begin
              if (count_q != CNT_MAX) count_q <= count_q + 1'b1;
              state_q <= S_MUL_XY;
            end
          end
        end
        S_MUL_XY, S_MUL_XX, S_MUL_MXY, S_MUL_MXX: begin
          if (mul_start) run_q <= 1'b1;
          if (mul_done) begin
            run_q <= 1'b0;
            case (state_q)
              S_MUL_XY:  state_q <= S_MUL_XX;
              S_MUL_XX:  state_q <= S_MEAN;
              S_MUL_MXY: state_q <= S_MUL_MXX;
              default:   state_q <= S_SLOPE;
            endcase
          end
        end
        S_MEAN: begin
          if (div_req.start) run_q <= 1'b1;
          if (div_rsp.done) begin
            run_q <= 1'b0;
            case (sel_q)
              2'd0:    mean_x_q   <= mnew[rrs_pkg::VAL_W-1:0];
              2'd1:    mean_y_q   <= mnew[rrs_pkg::VAL_W-1:0];
              2'd2:    mean_xy_q  <= mnew;
              default: mean_xsq_q <= mnew;
            endcase
            sel_q <= sel_q + 2'd1;
            if (sel_q == 2'd3) state_q <= S_MUL_MXY;
          end
        end
        S_SLOPE: begin
          if (div_req.start) run_q <= 1'b1;
          if (!run_q && dmag == '0) begin
            state_q <= S_OUT;  // zero variance, no division
          end else if (div_rsp.done) begin
            run_q   <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      x_q <= x_value_i;
      y_q <= y_value_i;
    end
    if (mul_done) begin
      case (state_q)
        S_MUL_XY, S_MUL_MXY: pa_q <= mul_p;
        default:             pb_q <= mul_p;
      endcase
    end
    if (div_req.start && state_q == S_MEAN) mneg_q <= mneg;
    if (state_q == S_SLOPE && !run_q) begin
      sneg_q <= ndiff[rrs_pkg::PROD_W] ^ ddiff[rrs_pkg::PROD_W];
      dneg_q <= (dmag == '0);
    end
    if (state_q == S_SLOPE && run_q && div_rsp.done) begin
      slope_q <= sat_slope;
      degen_q <= 1'b0;
      pcnt_q  <= cnt_show;
    end else if (state_q == S_SLOPE && !run_q && dmag == '0) begin
      slope_q <= '0;
      degen_q <= 1'b1;
      pcnt_q  <= cnt_show;
    end
  end

  // output register: held while a word waits on out_ready_i
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oslope_q <= '0;
      odegen_q <= 1'b0;
      opcnt_q  <= '0;
    end else if (out_load) begin
      oslope_q <= slope_q;
      odegen_q <= degen_q & dneg_q;
      opcnt_q  <= pcnt_q;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign slope_o       = oslope_q;
  assign degenerate_o  = odegen_q;
  assign point_count_o = opcnt_q;

endmodule

### test/tb.sv
// tb: self-checking bench for running_regression_slope_unit, all checks in this file
// depends on sv/rrs_pkg.sv, sv/rrs_mul.sv, sv/rrs_div.sv and sv/running_regression_slope_unit.sv
// drives (mode, x, y) words, predicts slope / degenerate flag / point count per word
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CNT_BITS  = 16;
  localparam int unsigned FRAC      = 16;
  localparam int unsigned WD_LIMIT  = 20000;  // idle bound: outlasts the long hold-off, with margin
  localparam int unsigned HOLD_LEN  = 3000;
  localparam int unsigned PAUSE_AT  = 400;    // sender drains the pipe before this word
  localparam int unsigned N_RANDOM  = 530;

  typedef struct packed {
    logic               clear;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } sample_t;

  typedef struct packed {
    logic [31:0] slope;
    logic        degen;
    logic [15:0] pcnt;
  } fit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic signed [31:0] x_value_i = '0;
  logic signed [31:0] y_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] slope_o;
  logic degenerate_o;
  logic [15:0] point_count_o;

  running_regression_slope_unit #(
    .COUNT_BITS(CNT_BITS),
    .FRAC_BITS (FRAC)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slope_o      (slope_o),
    .degenerate_o (degenerate_o),
    .point_count_o(point_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: point count and running means, all held at 64 bits
  logic [63:0]        pts;
  logic signed [63:0] avg_x, avg_y, avg_xy, avg_xsq;

  sample_t pending[$];
  fit_t    fit_queue[$];
  int      fails = 0;
  int      words_sent = 0;
  int      words_seen = 0;
  logic    took_in = 1'b0;

  // magnitude of a - b, modulo 2^64, sign in neg
  function automatic logic [63:0] mag_diff(input logic signed [63:0] a,
                                           input logic signed [63:0] b,
                                           output logic neg);
    neg = (a < b);
    return neg ? b - a : a - b;
  endfunction

  // mean += (v - mean) / n, truncating toward zero
  function automatic logic signed [63:0] mean_step(input logic signed [63:0] m,
                                                   input logic signed [63:0] v,
                                                   input logic [63:0] n);
    logic        neg;
    logic [63:0] q;
    q = mag_diff(v, m, neg) / n;
    return neg ? m - q : m + q;
  endfunction

  // least-squares slope from the current means, saturated to 32 bits
  function automatic fit_t slope_of_means();
    fit_t        f;
    logic        nneg, dneg, big;
    logic [63:0] nmag, dmag, r, q, bitv;
    nmag = mag_diff(avg_xy, avg_x * avg_y, nneg);
    dmag = mag_diff(avg_xsq, avg_x * avg_x, dneg);
    f.pcnt = (pts > 64'hFFFF) ? 16'hFFFF : pts[15:0];
    f.degen = (dmag == 0);
    f.slope = '0;
    if (dmag != 0) begin
      r = '0;
      q = '0;
      big = 1'b0;
      // long division of nmag * 2^FRAC, one quotient bit per step
      for (int i = 63 + FRAC; i >= 0; i--) begin
        bitv = (i >= FRAC) ? ((nmag >> (i - FRAC)) & 64'd1) : 64'd0;
        r = (r << 1) | bitv;
        if (r >= dmag) begin
          r = r - dmag;
          bitv = 64'd1;
        end else begin
          bitv = 64'd0;
        end
        if (!big) begin
          q = (q << 1) | bitv;
          if (q > 64'hFFFF_FFFF) big = 1'b1;
        end
      end
      if (nneg != dneg) begin
        f.slope = (big || q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      end else begin
        f.slope = (big || q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
    end
    return f;
  endfunction

  // fold one accepted word into the means and queue the expected fit
  task automatic fold_word(input sample_t s);
    logic signed [63:0] xs, ys;
    xs = s.x;
    ys = s.y;
    if (s.clear) begin
      pts = '0;
      avg_x = '0;
      avg_y = '0;
      avg_xy = '0;
      avg_xsq = '0;
    end else begin
      if (pts < (64'd1 << CNT_BITS) - 1) pts = pts + 1;
      avg_x   = mean_step(avg_x, xs, pts);
      avg_y   = mean_step(avg_y, ys, pts);
      avg_xy  = mean_step(avg_xy, xs * ys, pts);
      avg_xsq = mean_step(avg_xsq, xs * xs, pts);
    end
    fit_queue.push_back(slope_of_means());
  endtask

  // random value of random bit width, sign-extended, so small and huge both occur
  function automatic logic signed [31:0] rnd_q16();
    int unsigned w;
    logic signed [31:0] v;
    w = $urandom_range(1, 32);
    v = $urandom;
    return (v <<< (32 - w)) >>> (32 - w);
  endfunction

  task automatic add_word(input logic clear, input logic signed [31:0] x,
                          input logic signed [31:0] y);
    sample_t s;
    s.clear = clear;
    s.x = x;
    s.y = y;
    pending.push_back(s);
  endtask

  // stimulus: directed words first, then mostly point streams with the odd clear
  initial begin
    logic signed [31:0] a, b, xv;
    pts = '0;
    avg_x = '0;
    avg_y = '0;
    avg_xy = '0;
    avg_xsq = '0;
    // clear on empty state, then a single point (zero variance)
    add_word(1'b1, 32'sh1234_5678, -32'sd1);
    add_word(1'b0, 32'sh0001_0000, 32'sh0002_0000);
    // same x again: still zero variance
    add_word(1'b0, 32'sh0001_0000, 32'sh7FFF_FFFF);
    // field extremes
    add_word(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_word(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_word(1'b0, 32'sh8000_0000, 32'sh8000_0000);
    add_word(1'b0, -32'sd1, -32'sd1);
    add_word(1'b0, 32'sd0, 32'sd0);
    // clear with busy x/y, then a steep positive line (positive saturation)
    add_word(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_word(1'b0, 32'sd0, 32'sh8000_0000);
    add_word(1'b0, 32'sd1, 32'sh7FFF_FFFF);
    add_word(1'b0, 32'sd2, 32'sh7FFF_FFFF);
    // steep negative line
    add_word(1'b1, 32'sd0, 32'sd0);
    add_word(1'b0, 32'sd0, 32'sh7FFF_FFFF);
    add_word(1'b0, 32'sd1, 32'sh8000_0000);
    add_word(1'b0, 32'sd2, 32'sh8000_0000);
    // clean slope of 3 in Q16.16
    add_word(1'b1, 32'sd0, 32'sd0);
    for (int i = 0; i < 4; i++)
      add_word(1'b0, 32'(i) <<< 16, (32'(3 * i) <<< 16) - 32'sh0000_8000);
    add_word(1'b0, -32'sd1, 32'sd0);
    // random part: lines with noise, wild values, and occasional clears
    a = rnd_q16();
    b = rnd_q16();
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 99) < 5) begin
        add_word(1'b1, $urandom, $urandom);
        a = rnd_q16() >>> $urandom_range(0, 20);
        b = rnd_q16();
      end else if ($urandom_range(0, 99) < 70) begin
        xv = rnd_q16() >>> $urandom_range(0, 12);
        add_word(1'b0, xv, 32'((64'(a) * 64'(xv)) >>> FRAC) + b + (rnd_q16() >>> 12));
      end else begin
        add_word(1'b0, rnd_q16(), rnd_q16());
      end
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (pending.size() == 0 && !in_valid_i && fit_queue.size() == 0);
    repeat (600) @(posedge clk_i);
    if (fails == 0 && fit_queue.size() == 0) begin
      $display("running_regression_slope_unit: match");
    end else begin
      $display("running_regression_slope_unit: mismatch");
    end
    $finish;
  end

  // sender: new word at the falling edge once the last one was taken
  // idles about a quarter of the time, never for words 150..249, and
  // stops before word PAUSE_AT until every queued fit has come back
  always @(negedge clk_i) begin
    logic    go;
    sample_t s;
    if (rst_ni && (!in_valid_i || took_in)) begin
      go = pending.size() != 0;
      if (words_sent == PAUSE_AT && fit_queue.size() != 0) go = 1'b0;
      if (!(words_sent >= 150 && words_sent < 250) && $urandom_range(0, 99) < 24) go = 1'b0;
      if (go) begin
        s = pending.pop_front();
        mode_i <= s.clear;
        x_value_i <= s.x;
        y_value_i <= s.y;
        words_sent <= words_sent + 1;
      end
      in_valid_i <= go;
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off that backs the block up
  int hold_cnt = 0;
  always @(negedge clk_i) begin
    if (words_seen == 50 && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else if (words_seen >= 150 && words_seen < 250) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 24);
    end
  end

  // monitor: predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    fit_t want;
    took_in <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) fold_word({mode_i, x_value_i, y_value_i});
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen <= words_seen + 1;
      if (fit_queue.size() == 0) begin
        $display("%0t: unexpected word slope %h degen %b count %0d", $time,
                 slope_o, degenerate_o, point_count_o);
        fails++;
      end else begin
        want = fit_queue.pop_front();
        if (slope_o !== want.slope) begin
          $display("%0t: slope exp %h got %h", $time, want.slope, slope_o);
          fails++;
        end
        if (degenerate_o !== want.degen) begin
          $display("%0t: degenerate exp %b got %b", $time, want.degen, degenerate_o);
          fails++;
        end
        if (point_count_o !== want.pcnt) begin
          $display("%0t: point_count exp %0d got %0d", $time, want.pcnt, point_count_o);
          fails++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("running_regression_slope_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
